// ===== hw/rtl/ttb_pkg.sv =====
// ----------------------------------------------------------------------------
// ttb_pkg
// Shared types and widths for the triangle tangent/bitangent block.
// ----------------------------------------------------------------------------
package ttb_pkg;

  // Width of every coordinate and every result component.
  localparam int unsigned CoordW = 32;
  // Width of an edge delta (difference of two coordinates).
  localparam int unsigned DeltaW = CoordW + 1;
  // Width of one delta product.
  localparam int unsigned ProdW  = 2 * DeltaW;
  // Width of a numerator or determinant (difference of two products).
  localparam int unsigned NumW   = ProdW + 1;
  // Number of vector components in one request result.
  localparam int unsigned NumComp = 6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_MUL_D,
    ST_CHECK,
    ST_DIV_SETUP,
    ST_DIV_RUN,
    ST_DIV_DONE,
    ST_OUT
  } ttb_state_t;

endpackage

// ===== hw/rtl/triangle_tangent_bitangent.sv =====
// ----------------------------------------------------------------------------
// triangle_tangent_bitangent
// Per-triangle tangent and bitangent from three streamed vertices.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Payload
//  --------+-----------+---------------------------------------------------
//  s_*     | in        | one vertex: position x/y/z, texture u/v (Q16.16)
//  m_*     | out       | tangent x/y/z, bitangent x/y/z, degenerate, saturated
//
// The first two vertices of a triangle are only stored, and the block is
// ready again in the next cycle. The third vertex starts a sequence that
// uses one 33x33 multiplier and one bit-serial divider: seven product
// pairs, each through MUL_A, MUL_B and MUL_D, a check state to test the
// determinant, and six divisions (setup, 32 quotient bits, write-back).
// m_tvalid rises at the end of the sequence, and the result then waits in
// the output register.
// A zero determinant goes from the check state straight to the output state.
// Reset (rst, synchronous) returns the block to the first corner. While the
// result is not taken, no new vertex is accepted.
//
module triangle_tangent_bitangent
  import ttb_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  // position_x, position_y, position_z, tex_u, tex_v (lowest bits first)
  input  logic [5*CoordW-1:0]     s_tdata,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  // tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y, bitangent_z
  output logic [NumComp*CoordW-1:0] m_tdata,
  // degenerate, saturated (lowest bit first)
  output logic [1:0]              m_tuser
);

  // The numerator magnitude shifted up by the fraction bits.
  localparam int unsigned XW = NumW + FRAC_BITS;
  // Compare width for the quotient overflow test (divisor moved up 32 bits).
  localparam int unsigned CW = NumW + CoordW;
  localparam int unsigned CntW = $clog2(CoordW);

  ttb_state_t state, state_next;

  logic [1:0] corner;
  logic signed [CoordW-1:0] p0 [3];
  logic signed [CoordW-1:0] p1 [3];
  logic signed [CoordW-1:0] uv0 [2];
  logic signed [CoordW-1:0] uv1 [2];

  // Edge deltas of the triangle being worked on.
  logic signed [DeltaW-1:0] dp1 [3];
  logic signed [DeltaW-1:0] dp2 [3];
  logic signed [DeltaW-1:0] du1, dv1, du2, dv2;

  logic signed [ProdW-1:0] prod, acc;
  logic signed [NumW-1:0]  det, num;
  logic                    is_det;
  logic                    kind;   // 0 for tangent, 1 for bitangent
  logic [1:0]              comp;

  // Divider registers.
  logic [NumW-1:0]   dmag;
  logic [NumW-1:0]   rem;
  logic [CoordW-1:0] xlo;
  logic [CoordW-1:0] quo;
  logic              big;
  logic              qneg;
  logic [CntW-1:0]   cnt;

  logic [CoordW-1:0] res [NumComp];
  logic              degenerate, saturated;

  logic s_fire, m_fire;
  logic mul_half;
  logic signed [DeltaW-1:0] op_a, op_b;
  logic signed [ProdW-1:0]  mul_out;
  logic signed [NumW-1:0]   diff;
  logic [CoordW-1:0]        in_w [5];

  // Division helpers.
  logic [NumW-1:0]   nmag;
  logic [XW-1:0]     xval;
  logic [CW-1:0]     xext;
  logic [NumW:0]     trial;
  logic              take;
  logic [CoordW-1:0] sat_val;
  logic              sat_hit;
  logic [2:0]        res_idx;

  assign s_fire = s_tvalid && s_tready;
  assign m_fire = m_tvalid && m_tready;

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      in_w[i] = s_tdata[i*CoordW +: CoordW];
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_fire && corner >= 2'd2) state_next = ST_MUL_A;
      end
      ST_MUL_A: state_next = ST_MUL_B;
      ST_MUL_B: state_next = ST_MUL_D;
      ST_MUL_D: state_next = is_det ? ST_CHECK : ST_DIV_SETUP;
      ST_CHECK: state_next = (det == '0) ? ST_OUT : ST_MUL_A;
      ST_DIV_SETUP: state_next = ST_DIV_RUN;
      ST_DIV_RUN: begin
        if (cnt == CntW'(CoordW - 1)) state_next = ST_DIV_DONE;
      end
      ST_DIV_DONE: begin
        if (kind && comp == 2'd2) state_next = ST_OUT;
        else state_next = ST_MUL_A;
      end
      ST_OUT: begin
        if (m_fire) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    s_tready = 1'b0;
    m_tvalid = 1'b0;
    mul_half = 1'b0;
    unique case (state)
      ST_IDLE:  s_tready = 1'b1;
      ST_MUL_B: mul_half = 1'b1;
      ST_OUT:   m_tvalid = 1'b1;
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  // Operand selection for the shared multiplier. Each numerator and the
  // determinant are a difference of two products taken in two halves.
  always_comb begin
    if (is_det) begin
      op_a = mul_half ? dv1 : du1;
      op_b = mul_half ? du2 : dv2;
    end else if (!kind) begin
      op_a = mul_half ? dp2[comp] : dp1[comp];
      op_b = mul_half ? dv1 : dv2;
    end else begin
      op_a = mul_half ? dp1[comp] : dp2[comp];
      op_b = mul_half ? du2 : du1;
    end
  end

  assign mul_out = op_a * op_b;
  assign diff    = NumW'(acc) - NumW'(prod);

  // Divider datapath: magnitude, the widened operand for the overflow test and one restoring step.
  always_comb begin
    nmag  = num[NumW-1] ? NumW'(-num) : NumW'(num);
    xval  = {nmag, {FRAC_BITS{1'b0}}};
    xext  = CW'(xval);
    trial = {rem, xlo[CoordW-1]};
    take  = trial >= {1'b0, dmag};
  end

  // Saturation of the finished quotient.
  always_comb begin
    sat_hit = 1'b0;
    if (qneg) begin
      if (big || quo > {1'b1, {(CoordW-1){1'b0}}}) begin
        sat_val = {1'b1, {(CoordW-1){1'b0}}};
        sat_hit = 1'b1;
      end else begin
        sat_val = -quo;
      end
    end else begin
      if (big || quo[CoordW-1]) begin
        sat_val = {1'b0, {(CoordW-1){1'b1}}};
        sat_hit = 1'b1;
      end else begin
        sat_val = quo;
      end
    end
    res_idx = kind ? (3'd3 + 3'(comp)) : 3'(comp);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      corner <= 2'd0;
    end else begin
      state <= state_next;
      if (s_fire) corner <= (corner >= 2'd2) ? 2'd0 : corner + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (s_fire) begin
          if (corner == 2'd0) begin
            for (int i = 0; i < 3; i++) p0[i] <= in_w[i];
            uv0[0] <= in_w[3];
            uv0[1] <= in_w[4];
          end else if (corner == 2'd1) begin
            for (int i = 0; i < 3; i++) p1[i] <= in_w[i];
            uv1[0] <= in_w[3];
            uv1[1] <= in_w[4];
          end else begin
            for (int i = 0; i < 3; i++) begin
              dp1[i] <= DeltaW'(p1[i]) - DeltaW'(p0[i]);
              dp2[i] <= DeltaW'($signed(in_w[i])) - DeltaW'(p0[i]);
            end
            du1 <= DeltaW'(uv1[0]) - DeltaW'(uv0[0]);
            dv1 <= DeltaW'(uv1[1]) - DeltaW'(uv0[1]);
            du2 <= DeltaW'($signed(in_w[3])) - DeltaW'(uv0[0]);
            dv2 <= DeltaW'($signed(in_w[4])) - DeltaW'(uv0[1]);
            is_det <= 1'b1;
          end
        end
      end
      ST_MUL_A: prod <= mul_out;
      ST_MUL_B: begin
        acc  <= prod;
        prod <= mul_out;
      end
      ST_MUL_D: begin
        if (is_det) det <= diff;
        else num <= diff;
      end
      ST_CHECK: begin
        is_det     <= 1'b0;
        kind       <= 1'b0;
        comp       <= 2'd0;
        saturated  <= 1'b0;
        degenerate <= (det == '0);
        if (det == '0) begin
          for (int i = 0; i < NumComp; i++) res[i] <= '0;
        end
        dmag <= det[NumW-1] ? NumW'(-det) : NumW'(det);
      end
      ST_DIV_SETUP: begin
        qneg <= num[NumW-1] ^ det[NumW-1];
        big  <= xext >= {dmag, {CoordW{1'b0}}};
        rem  <= xext[CW-1:CoordW];
        xlo  <= xval[CoordW-1:0];
        quo  <= '0;
        cnt  <= '0;
      end
      ST_DIV_RUN: begin
        rem <= take ? NumW'(trial - {1'b0, dmag}) : NumW'(trial);
        xlo <= {xlo[CoordW-2:0], 1'b0};
        quo <= {quo[CoordW-2:0], take};
        cnt <= cnt + CntW'(1);
      end
      ST_DIV_DONE: begin
        res[res_idx] <= sat_val;
        if (sat_hit) saturated <= 1'b1;
        if (kind) begin
          kind <= 1'b0;
          comp <= comp + 2'd1;
        end else begin
          kind <= 1'b1;
        end
      end
      ST_OUT: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < NumComp; i++) begin
      m_tdata[i*CoordW +: CoordW] = res[i];
    end
    m_tuser = {saturated, degenerate};
  end

  // Input and output are never both open: one triangle at a time.
  assert property (@(posedge clk) disable iff (rst) !(s_tready && m_tvalid))
    else $error("input accepted while a result is pending");

  // A degenerate result carries zero vectors and no saturation.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata == '0 && !m_tuser[1]))
    else $error("degenerate result is not clean");

  // The first two corners only store, so the block is ready right after.
  assert property (@(posedge clk) disable iff (rst)
    (s_fire && corner < 2'd2) |=> s_tready)
    else $error("stalled after a stored corner");

  // A result is held until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("pending result changed");

endmodule

// ===== dv/tb_triangle_tangent_bitangent.sv =====
// ----------------------------------------------------------------------------
// tb_triangle_tangent_bitangent
// Self-checking stream testbench for the triangle tangent/bitangent block.
// ----------------------------------------------------------------------------
// Vertices are streamed in as requests. Every third vertex closes a triangle,
// and the block answers with the shared tangent and bitangent. A behavioral
// predictor works out each result in wide integer arithmetic. A queue holds
// the expected results, and each result the block returns is checked against
// the oldest entry. A directed table comes first and covers degenerate UVs,
// the extreme coordinates and saturation. Random triangles follow it,
// first with random handshake gaps and then with none.
// ----------------------------------------------------------------------------
module tb_triangle_tangent_bitangent;
  timeunit 1ns;
  timeprecision 1ps;
  import ttb_pkg::*;

  localparam int FracBits = 16;
  localparam logic [31:0] MaxPos = 32'h7FFF_FFFF;
  localparam logic [31:0] MaxNeg = 32'h8000_0000;

  typedef struct packed {
    logic [31:0] pos_x, pos_y, pos_z, tex_u, tex_v;
  } vertex_t;

  typedef struct packed {
    logic [5:0][31:0] comp;   // tangent x/y/z then bitangent x/y/z
    logic             degen;
    logic             sat;
  } frame_t;

  // One row of the directed table. When check_lit is set, lit_res is a
  // result typed in by hand, which the predictor must match for that row.
  typedef struct {
    vertex_t vtx;
    bit      check_lit;
    frame_t  lit_res;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [5*CoordW-1:0]  s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [NumComp*CoordW-1:0] m_tdata;
  logic [1:0]           m_tuser;

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  failed = 1'b0;

  frame_t  pending_tbn[$];
  vertex_t corner0, corner1;
  int      corner_no = 0;

  always #1 clk = ~clk;

  triangle_tangent_bitangent #(.FRAC_BITS(FracBits)) u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  // The quotient (num << FracBits) / det is truncated toward zero, then
  // clipped to 32 bits. The numerator fits in 67 bits, and the shift widens
  // it to 83 bits, so 160 bits of headroom is enough.
  function automatic logic [31:0] scaled_quotient(input logic signed [159:0] num,
                                                  input logic signed [159:0] det,
                                                  inout logic sat);
    logic signed [159:0] q;
    q = (num <<< FracBits) / det;
    if (q > 160'sd2147483647) begin
      sat = 1'b1;
      return MaxPos;
    end
    if (q < -160'sd2147483648) begin
      sat = 1'b1;
      return MaxNeg;
    end
    return q[31:0];
  endfunction

  // Compute the tangent frame of one triangle from its three corners.
  function automatic frame_t tangent_frame(input vertex_t a, input vertex_t b,
                                           input vertex_t c);
    logic signed [159:0] dp1[3], dp2[3], du1, dv1, du2, dv2, det, tn, bn;
    logic [2:0][31:0] pa, pb, pc;
    frame_t r;
    logic sat;
    pa = {a.pos_z, a.pos_y, a.pos_x};
    pb = {b.pos_z, b.pos_y, b.pos_x};
    pc = {c.pos_z, c.pos_y, c.pos_x};
    for (int k = 0; k < 3; k++) begin
      dp1[k] = 160'($signed(pb[k])) - 160'($signed(pa[k]));
      dp2[k] = 160'($signed(pc[k])) - 160'($signed(pa[k]));
    end
    du1 = 160'($signed(b.tex_u)) - 160'($signed(a.tex_u));
    dv1 = 160'($signed(b.tex_v)) - 160'($signed(a.tex_v));
    du2 = 160'($signed(c.tex_u)) - 160'($signed(a.tex_u));
    dv2 = 160'($signed(c.tex_v)) - 160'($signed(a.tex_v));
    det = du1 * dv2 - dv1 * du2;
    r = '0;
    if (det == 0) begin
      r.degen = 1'b1;
      return r;
    end
    sat = 1'b0;
    for (int k = 0; k < 3; k++) begin
      tn = dp1[k] * dv2 - dp2[k] * dv1;
      bn = dp2[k] * du1 - dp1[k] * du2;
      r.comp[k]     = scaled_quotient(tn, det, sat);
      r.comp[3 + k] = scaled_quotient(bn, det, sat);
    end
    r.sat = sat;
    return r;
  endfunction

  // Track the corner position and queue a result on every third corner.
  function automatic void accept_vertex(input vertex_t v);
    case (corner_no)
      0: begin
        corner0 = v;
        corner_no = 1;
      end
      1: begin
        corner1 = v;
        corner_no = 2;
      end
      default: begin
        pending_tbn.push_back(tangent_frame(corner0, corner1, v));
        corner_no = 0;
      end
    endcase
  endfunction

  // Send one vertex. The valid is held for as long as the block stalls.
  // Between requests, a random gap may lower it.
  task automatic send_vertex(input vertex_t v);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {v.tex_v, v.tex_u, v.pos_z, v.pos_y, v.pos_x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    accept_vertex(v);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return MaxPos - $urandom_range(3);
      2: return MaxNeg + $urandom_range(3);
      3: return 32'($signed($urandom_range(8192)) - 4096) << FracBits;
      default: return 32'($signed($urandom_range(65535)) - 32768) << $urandom_range(12);
    endcase
  endfunction

  function automatic vertex_t rand_vertex();
    vertex_t v;
    v.pos_x = rand_coord();
    v.pos_y = rand_coord();
    v.pos_z = rand_coord();
    v.tex_u = rand_coord();
    v.tex_v = rand_coord();
    return v;
  endfunction

  // The receiver accepts the result and checks it against the oldest
  // expected result.
  always @(posedge clk) begin
    frame_t got, want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.comp  = m_tdata;
        got.degen = m_tuser[0];
        got.sat   = m_tuser[1];
        if (pending_tbn.size() == 0) begin
          $display("%0t: unexpected result %h", $realtime, got);
          failed = 1'b1;
        end else begin
          want = pending_tbn.pop_front();
          for (int k = 0; k < 6; k++)
            if (got.comp[k] !== want.comp[k]) begin
              $display("%0t: component %0d expected %h actual %h", $realtime, k,
                       want.comp[k], got.comp[k]);
              failed = 1'b1;
            end
          if (got.degen !== want.degen) begin
            $display("%0t: degenerate expected %b actual %b", $realtime,
                     want.degen, got.degen);
            failed = 1'b1;
          end
          if (got.sat !== want.sat) begin
            $display("%0t: saturated expected %b actual %b", $realtime,
                     want.sat, got.sat);
            failed = 1'b1;
          end
        end
      end
      m_tready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
    end
  end

  // This limit is far beyond the slowest correct run of about 620 triangles,
  // plus long receiver stalls.
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    dir_row_t dir_rows[$];
    dir_row_t row;
    frame_t lit;
    vertex_t z, v;
    int n_rand;
    z = '0;

    // A triangle with all corners at zero has no UV area, so it is degenerate.
    lit = '0;
    lit.degen = 1'b1;
    dir_rows.push_back('{z, 0, '0});
    dir_rows.push_back('{z, 0, '0});
    dir_rows.push_back('{z, 1, lit});
    // A unit right triangle in UV space gives the position edges themselves.
    dir_rows.push_back('{'{0, 0, 0, 0, 0}, 0, '0});
    dir_rows.push_back('{'{32'h1_0000, 0, 0, 32'h1_0000, 0}, 0, '0});
    lit = '0;
    lit.comp[0] = 32'h1_0000;
    lit.comp[4] = 32'h1_0000;
    dir_rows.push_back('{'{0, 32'h1_0000, 0, 0, 32'h1_0000}, 1, lit});
    // Extreme positions over a tiny UV triangle drive five of the six
    // components into clipping.
    dir_rows.push_back('{'{MaxNeg, MaxNeg, MaxNeg, 0, 0}, 0, '0});
    dir_rows.push_back('{'{MaxPos, MaxPos, MaxPos, 1, 0}, 0, '0});
    dir_rows.push_back('{'{MaxPos, MaxNeg, MaxPos, 0, 1}, 0, '0});
    // Extreme UVs that lie on one line are collinear, so the result is
    // degenerate.
    lit = '0;
    lit.degen = 1'b1;
    dir_rows.push_back('{'{MaxPos, 0, MaxNeg, MaxNeg, MaxNeg}, 0, '0});
    dir_rows.push_back('{'{0, MaxPos, 0, MaxPos, MaxPos}, 0, '0});
    dir_rows.push_back('{'{MaxNeg, 1, MaxPos, 0, 0}, 1, lit});
    // Two triangles with extreme UVs; the first also has positions with all bits set.
    dir_rows.push_back('{'{32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, MaxNeg, MaxPos}, 0, '0});
    dir_rows.push_back('{'{0, 32'hFFFF_FFFF, 0, MaxPos, MaxNeg}, 0, '0});
    dir_rows.push_back('{'{MaxPos, MaxNeg, 1, MaxPos, MaxPos}, 0, '0});
    dir_rows.push_back('{'{1, 2, 3, MaxNeg, 0}, 0, '0});
    dir_rows.push_back('{'{MaxNeg, MaxPos, 0, 0, MaxNeg}, 0, '0});
    dir_rows.push_back('{'{5, 6, 7, MaxPos, 32'h1}, 0, '0});

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.check_lit && tangent_frame(corner0, corner1, row.vtx) !== row.lit_res) begin
        $display("%0t: table row %0d expected %h actual %h", $realtime, i,
                 row.lit_res, tangent_frame(corner0, corner1, row.vtx));
        failed = 1'b1;
      end
      send_vertex(row.vtx);
    end

    // Random triangles are sent in three phases of handshake gaps, the last
    // with none. Some reuse a UV so that degenerate triangles keep coming.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 88 : 0;
      recv_idle_pct = (phase == 0) ? 88 : (phase == 1) ? 22 : 0;
      n_rand = (phase == 2) ? 633 : 600;
      for (int i = 0; i < n_rand; i++) begin
        v = rand_vertex();
        if (corner_no == 2 && $urandom_range(9) == 0) begin
          v.tex_u = corner1.tex_u;
          v.tex_v = corner1.tex_v;
        end
        send_vertex(v);
      end
    end
    s_tvalid <= 1'b0;

    while (pending_tbn.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (!failed) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
hw/rtl/ttb_pkg.sv
hw/rtl/triangle_tangent_bitangent.sv
dv/tb_triangle_tangent_bitangent.sv
